@@ hdl/chce_pkg.sv @@
// Shared types and constants for the cubic Hermite tone-curve evaluator.
// Used by chce_div and cubic_hermite_curve_eval; depends on nothing else.
package chce_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int VAL_W        = 17;
    localparam int IDX_W        = 4;
    localparam int TAN_INT_BITS = 8;
    localparam int SLOPE_W      = TAN_INT_BITS + FRAC_BITS + 1;
    localparam int M_W          = 27;
    localparam int H_W          = 20;

    localparam int DIV_NUM_W    = 34;
    localparam int DIV_DEN_W    = 19;
    localparam int DIV_REM_W    = 19;
    localparam int DIV_Q_W      = 24;
    localparam int DIV_CNT_W    = 5;

    localparam int MUL_W        = 28;
    localparam int PROD_W       = 2 * MUL_W;

    localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [SLOPE_W-1:0] TAN_LIMIT =
        SLOPE_W'((1 << (TAN_INT_BITS + FRAC_BITS)) - 1);

    localparam logic [DIV_CNT_W-1:0] T_QBITS     = DIV_CNT_W'(FRAC_BITS);
    localparam logic [DIV_CNT_W-1:0] SLOPE_QBITS = DIV_CNT_W'(TAN_INT_BITS + FRAC_BITS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_CHK0, S_CHKL, S_SRCH, S_SEG, S_TDIV,
        S_SLLO, S_SLHI, S_SLPR, S_SLDV, S_SLMU, S_SLST,
        S_T2, S_T3, S_H, S_M0, S_M1, S_M2, S_M3, S_M4, S_RND, S_OUT
    } state_t;

endpackage

@@ hdl/chce_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, run length set per start.
// Depends on chce_pkg.
module chce_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [chce_pkg::DIV_NUM_W-1:0]      num,
    input  logic [chce_pkg::DIV_DEN_W-1:0]      den,
    input  logic [chce_pkg::DIV_CNT_W-1:0]      qbits,
    output chce_pkg::div_stat_t                 stat,
    output logic [chce_pkg::DIV_Q_W-1:0]        quo
);

    logic [chce_pkg::DIV_REM_W-1:0] rem_reg;
    logic [chce_pkg::DIV_NUM_W-1:0] nsh_reg;
    logic [chce_pkg::DIV_DEN_W-1:0] den_reg;
    logic [chce_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [chce_pkg::DIV_Q_W-1:0]   quo_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [chce_pkg::DIV_REM_W:0]   trial;
    logic                           ge;
    logic [5:0]                     lsh;

    // High part of the numerator seeds the remainder; the rest shifts in MSB first.
    assign lsh   = 6'(chce_pkg::DIV_NUM_W) - {1'b0, qbits};
    assign trial = {rem_reg, nsh_reg[chce_pkg::DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= qbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == chce_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= chce_pkg::DIV_REM_W'(num >> qbits);
            nsh_reg <= num << lsh;
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? chce_pkg::DIV_REM_W'(trial - {1'b0, den_reg})
                          : trial[chce_pkg::DIV_REM_W-1:0];
            nsh_reg <= nsh_reg << 1;
            quo_reg <= {quo_reg[chce_pkg::DIV_Q_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

@@ hdl/cubic_hermite_curve_eval.sv @@
// Tone-curve evaluator: control point table, segment search and cubic Hermite sum.
// Depends on chce_pkg and chce_div.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   tuser: op; tdata: index, x, y, query_x
//  m_        out  m_tvalid/m_tready   tdata: curve_value, segment_used
//  cfg_      in   cfg_wr_en           cfg_wr_data: point_count
//
// An evaluation returns its result early for an end case or a zero-width segment; else it
// runs the serial divider for t and once more for each tangent that does not saturate,
// and walks through the table one entry a cycle.
// s_tready returns the cycle after the result is taken.
// Reset clears the sequencer and point_count; the table holds garbage until written.
// s_tready is low from an evaluation's acceptance until its result is taken on m_.
module cubic_hermite_curve_eval #(
    parameter int MAX_POINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_index, point_x, point_y, query_x, zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // curve_value, segment_used, zero pad
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VW = chce_pkg::VAL_W;
    localparam int PW = chce_pkg::PROD_W;
    localparam int FB = chce_pkg::FRAC_BITS;

    chce_pkg::state_t state_reg, state_next;

    logic [4:0]                     count_reg;
    logic [VW-1:0]                  x_reg;
    logic [CW-1:0]                  n_reg;
    chce_pkg::point_t               mem [MAX_POINTS];
    chce_pkg::point_t               rd_q_reg;
    chce_pkg::point_t               prev_reg, p1_reg, lo_pt_reg;
    logic [AW-1:0]                  idx_reg, seg_reg;
    logic signed [VW:0]             dx_reg;
    logic [VW-1:0]                  t_reg, t2_reg;
    logic                           kk_reg, neg_reg;
    logic signed [chce_pkg::SLOPE_W-1:0] q_reg;
    logic signed [chce_pkg::M_W-1:0]     m0_reg, m1_reg;
    logic signed [chce_pkg::H_W-1:0]     h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [PW-1:0]           mul_reg, acc_reg;
    logic [VW-1:0]                  res_val_reg;
    logic [chce_pkg::IDX_W-1:0]     res_seg_reg;

    // input payload
    logic [chce_pkg::IDX_W-1:0]     in_idx;
    logic [VW-1:0]                  in_px, in_py, in_qx;
    logic                           in_acc, wr_en;
    logic [AW-1:0]                  wr_addr, rd_addr;
    logic [CW-1:0]                  nclip;

    // datapath helpers
    logic signed [VW:0]             dx_c;
    logic [VW-1:0]                  xo_c;
    logic [CW-1:0]                  sk, slo, shi;
    logic                           central;
    logic signed [VW:0]             sl_dy;
    logic signed [VW+1:0]           sl_den_raw;
    logic [chce_pkg::DIV_DEN_W-1:0] sl_den_base, sl_den;
    logic [VW-1:0]                  sl_mag;
    logic                           sl_sat;
    logic signed [chce_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]           pb_c, rnd_c;
    logic signed [chce_pkg::M_W-1:0] m_c;
    logic signed [chce_pkg::H_W-1:0] t1s, t2s, t3s;

    logic                           div_start;
    logic [chce_pkg::DIV_NUM_W-1:0] div_num;
    logic [chce_pkg::DIV_DEN_W-1:0] div_den;
    logic [chce_pkg::DIV_CNT_W-1:0] div_qbits;
    chce_pkg::div_stat_t            div_stat;
    logic [chce_pkg::DIV_Q_W-1:0]   div_quo;

    assign in_idx = s_tdata[3:0];
    assign in_px  = s_tdata[20:4];
    assign in_py  = s_tdata[37:21];
    assign in_qx  = s_tdata[54:38];
    assign in_acc = s_tvalid && s_tready;
    assign wr_en  = in_acc && (s_tuser == chce_pkg::OP_WRITE)
                    && (7'(in_idx) < 7'(MAX_POINTS));
    assign wr_addr = AW'(in_idx);
    assign nclip  = (7'(count_reg) > 7'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // control point table, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{x: in_px, y: in_py};
        end
        rd_q_reg <= mem[rd_addr];
    end

    // tangent end points for point seg + kk
    always_comb begin
        sk      = CW'(seg_reg) + CW'(kk_reg);
        central = 1'b0;
        if (sk == '0) begin
            slo = '0;
            shi = CW'(1);
        end else if (sk >= n_reg - 1'b1) begin
            slo = n_reg - CW'(2);
            shi = n_reg - CW'(1);
        end else begin
            slo     = sk - 1'b1;
            shi     = sk + 1'b1;
            central = 1'b1;
        end
    end

    assign dx_c = $signed({1'b0, p1_reg.x}) - $signed({1'b0, prev_reg.x});
    assign xo_c = x_reg - prev_reg.x;

    always_comb begin
        sl_dy       = $signed({1'b0, rd_q_reg.y}) - $signed({1'b0, lo_pt_reg.y});
        sl_den_raw  = $signed({2'b0, rd_q_reg.x}) - $signed({2'b0, lo_pt_reg.x})
                      + $signed((VW+2)'(1));
        sl_den_base = (sl_den_raw <= 0) ? chce_pkg::DIV_DEN_W'(1)
                                        : chce_pkg::DIV_DEN_W'(sl_den_raw);
        sl_den      = central ? (sl_den_base << 1) : sl_den_base;
        sl_mag      = sl_dy[VW] ? VW'(-sl_dy) : VW'(sl_dy);
        sl_sat      = {10'b0, sl_mag} >= {sl_den, 8'b0};
    end

    // truncate toward zero when dropping the fraction
    assign pb_c  = mul_reg + ((mul_reg < 0) ? $signed(PW'((1 << FB) - 1)) : $signed(PW'(0)));
    assign m_c   = chce_pkg::M_W'(pb_c >>> FB);
    assign rnd_c = (acc_reg + $signed(PW'(1 << (FB - 1)))) >>> FB;

    assign t1s = $signed(chce_pkg::H_W'(t_reg));
    assign t2s = $signed(chce_pkg::H_W'(t2_reg));
    assign t3s = $signed(chce_pkg::H_W'(mul_reg[FB+VW-1:FB]));

    always_comb begin
        unique case (state_reg)
            chce_pkg::S_IDLE: state_next = (in_acc && s_tuser == chce_pkg::OP_EVAL)
                                           ? chce_pkg::S_RD0 : chce_pkg::S_IDLE;
            chce_pkg::S_RD0:  state_next = (n_reg == '0) ? chce_pkg::S_OUT : chce_pkg::S_CHK0;
            chce_pkg::S_CHK0: state_next = (n_reg == CW'(1) || x_reg <= rd_q_reg.x)
                                           ? chce_pkg::S_OUT : chce_pkg::S_CHKL;
            chce_pkg::S_CHKL: state_next = (x_reg >= rd_q_reg.x)
                                           ? chce_pkg::S_OUT : chce_pkg::S_SRCH;
            chce_pkg::S_SRCH: state_next = (x_reg < rd_q_reg.x)
                                           ? chce_pkg::S_SEG : chce_pkg::S_SRCH;
            chce_pkg::S_SEG:  state_next = (dx_c <= 0) ? chce_pkg::S_OUT : chce_pkg::S_TDIV;
            chce_pkg::S_TDIV: state_next = div_stat.done ? chce_pkg::S_SLLO : chce_pkg::S_TDIV;
            chce_pkg::S_SLLO: state_next = chce_pkg::S_SLHI;
            chce_pkg::S_SLHI: state_next = chce_pkg::S_SLPR;
            chce_pkg::S_SLPR: state_next = sl_sat ? chce_pkg::S_SLMU : chce_pkg::S_SLDV;
            chce_pkg::S_SLDV: state_next = div_stat.done ? chce_pkg::S_SLMU : chce_pkg::S_SLDV;
            chce_pkg::S_SLMU: state_next = chce_pkg::S_SLST;
            chce_pkg::S_SLST: state_next = kk_reg ? chce_pkg::S_T2 : chce_pkg::S_SLLO;
            chce_pkg::S_T2:   state_next = chce_pkg::S_T3;
            chce_pkg::S_T3:   state_next = chce_pkg::S_H;
            chce_pkg::S_H:    state_next = chce_pkg::S_M0;
            chce_pkg::S_M0:   state_next = chce_pkg::S_M1;
            chce_pkg::S_M1:   state_next = chce_pkg::S_M2;
            chce_pkg::S_M2:   state_next = chce_pkg::S_M3;
            chce_pkg::S_M3:   state_next = chce_pkg::S_M4;
            chce_pkg::S_M4:   state_next = chce_pkg::S_RND;
            chce_pkg::S_RND:  state_next = chce_pkg::S_OUT;
            chce_pkg::S_OUT:  state_next = m_tready ? chce_pkg::S_IDLE : chce_pkg::S_OUT;
            default:          state_next = chce_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == chce_pkg::S_IDLE);
        m_tvalid  = (state_reg == chce_pkg::S_OUT);
        rd_addr   = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_qbits = chce_pkg::T_QBITS;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            chce_pkg::S_CHK0: rd_addr = AW'(n_reg - 1'b1);
            chce_pkg::S_CHKL: rd_addr = AW'(1);
            chce_pkg::S_SRCH: rd_addr = idx_reg + 1'b1;
            chce_pkg::S_SEG: begin
                div_start = (dx_c > 0);
                div_num   = chce_pkg::DIV_NUM_W'(xo_c) << FB;
                div_den   = chce_pkg::DIV_DEN_W'(dx_c);
            end
            chce_pkg::S_SLLO: rd_addr = AW'(slo);
            chce_pkg::S_SLHI: rd_addr = AW'(shi);
            chce_pkg::S_SLPR: begin
                div_start = !sl_sat;
                div_num   = chce_pkg::DIV_NUM_W'(sl_mag) << FB;
                div_den   = sl_den;
                div_qbits = chce_pkg::SLOPE_QBITS;
            end
            chce_pkg::S_SLMU: begin
                mul_a = chce_pkg::MUL_W'(q_reg);
                mul_b = chce_pkg::MUL_W'(dx_reg);
            end
            chce_pkg::S_T2: begin
                mul_a = $signed(chce_pkg::MUL_W'(t_reg));
                mul_b = $signed(chce_pkg::MUL_W'(t_reg));
            end
            chce_pkg::S_T3: begin
                mul_a = $signed(chce_pkg::MUL_W'(mul_reg[FB+VW-1:FB]));
                mul_b = $signed(chce_pkg::MUL_W'(t_reg));
            end
            chce_pkg::S_M0: begin
                mul_a = chce_pkg::MUL_W'(h00_reg);
                mul_b = $signed(chce_pkg::MUL_W'(prev_reg.y));
            end
            chce_pkg::S_M1: begin
                mul_a = chce_pkg::MUL_W'(h10_reg);
                mul_b = chce_pkg::MUL_W'(m0_reg);
            end
            chce_pkg::S_M2: begin
                mul_a = chce_pkg::MUL_W'(h01_reg);
                mul_b = $signed(chce_pkg::MUL_W'(p1_reg.y));
            end
            chce_pkg::S_M3: begin
                mul_a = chce_pkg::MUL_W'(h11_reg);
                mul_b = chce_pkg::MUL_W'(m1_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chce_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            chce_pkg::S_IDLE: begin
                x_reg <= in_qx;
                n_reg <= nclip;
            end
            chce_pkg::S_RD0: begin
                res_val_reg <= x_reg;
                res_seg_reg <= '0;
            end
            chce_pkg::S_CHK0: begin
                prev_reg    <= rd_q_reg;
                res_val_reg <= rd_q_reg.y;
            end
            chce_pkg::S_CHKL: begin
                res_val_reg <= rd_q_reg.y;
                idx_reg     <= AW'(1);
            end
            chce_pkg::S_SRCH: begin
                if (x_reg < rd_q_reg.x) begin
                    p1_reg  <= rd_q_reg;
                    seg_reg <= idx_reg - 1'b1;
                end else begin
                    prev_reg <= rd_q_reg;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            chce_pkg::S_SEG: begin
                dx_reg      <= dx_c;
                res_val_reg <= prev_reg.y;
                res_seg_reg <= chce_pkg::IDX_W'(seg_reg);
                kk_reg      <= 1'b0;
            end
            chce_pkg::S_TDIV: begin
                if (div_stat.done) begin
                    t_reg <= VW'(div_quo);
                end
            end
            chce_pkg::S_SLHI: lo_pt_reg <= rd_q_reg;
            chce_pkg::S_SLPR: begin
                neg_reg <= sl_dy[VW];
                q_reg   <= sl_dy[VW] ? -chce_pkg::TAN_LIMIT : chce_pkg::TAN_LIMIT;
            end
            chce_pkg::S_SLDV: begin
                if (div_stat.done) begin
                    q_reg <= neg_reg ? -$signed(chce_pkg::SLOPE_W'(div_quo))
                                     : $signed(chce_pkg::SLOPE_W'(div_quo));
                end
            end
            chce_pkg::S_SLST: begin
                if (kk_reg) begin
                    m1_reg <= m_c;
                end else begin
                    m0_reg <= m_c;
                end
                kk_reg <= 1'b1;
            end
            chce_pkg::S_T3: t2_reg <= mul_reg[FB+VW-1:FB];
            chce_pkg::S_H: begin
                h00_reg <= t3s + t3s - t2s - t2s - t2s
                           + $signed(chce_pkg::H_W'(chce_pkg::ONE));
                h10_reg <= t3s - t2s - t2s + t1s;
                h01_reg <= t2s + t2s + t2s - t3s - t3s;
                h11_reg <= t3s - t2s;
            end
            chce_pkg::S_M1: acc_reg <= mul_reg;
            chce_pkg::S_M2: acc_reg <= acc_reg + mul_reg;
            chce_pkg::S_M3: acc_reg <= acc_reg + mul_reg;
            chce_pkg::S_M4: acc_reg <= acc_reg + mul_reg;
            chce_pkg::S_RND: begin
                if (acc_reg <= 0) begin
                    res_val_reg <= '0;
                end else if (rnd_c > $signed(PW'(chce_pkg::ONE))) begin
                    res_val_reg <= chce_pkg::ONE;
                end else begin
                    res_val_reg <= VW'(rnd_c);
                end
            end
            default: ;
        endcase
    end

    chce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .qbits   (div_qbits),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    assign m_tdata = {3'b0, res_seg_reg, res_val_reg};

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chce_pkg::S_SRCH) |-> (CW'(idx_reg) < n_reg))
        else $error("segment search ran past the last point");

    a_t_below_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chce_pkg::S_T2) |-> (t_reg < chce_pkg::ONE))
        else $error("segment parameter t reached one");

endmodule

@@ dv/tb_cubic_hermite_curve_eval.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for cubic_hermite_curve_eval: a directed table, then random
// phases of control-point loads and curve evaluations checked against a local predictor.
// Depends on chce_pkg and the evaluator RTL.
module tb_cubic_hermite_curve_eval;

    localparam int VAL_W        = chce_pkg::VAL_W;
    localparam int IDX_W        = chce_pkg::IDX_W;
    localparam int FRAC_BITS    = chce_pkg::FRAC_BITS;
    localparam int TAN_INT_BITS = chce_pkg::TAN_INT_BITS;

    localparam int NPTS     = 16;
    localparam int WD_LIMIT = 6000;
    localparam int SETTLE   = 200;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint TAN_L = (longint'(1) << (TAN_INT_BITS + FRAC_BITS)) - 1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] seg;
    } curve_res_t;

    typedef struct {
        bit               is_cfg;
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] px;
        logic [VAL_W-1:0] py;
        logic [VAL_W-1:0] qx;
        bit               typed;
        curve_res_t       res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    cubic_hermite_curve_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the block state
    logic [VAL_W-1:0] tbl_x [NPTS];
    logic [VAL_W-1:0] tbl_y [NPTS];
    logic [4:0]       pt_count = '0;
    curve_res_t       curve_q[$];
    stim_row_t        dir_rows[$];
    bit               calm = 1'b0;
    int               errors = 0;
    int               idle_cycles = 0;

    function automatic longint tangent(int i, int n);
        int lo, hi;
        bit central;
        longint dy, den, q;
        central = 1'b0;
        if (i == 0) begin
            lo = 0; hi = 1;
        end else if (i >= n - 1) begin
            lo = n - 2; hi = n - 1;
        end else begin
            lo = i - 1; hi = i + 1; central = 1'b1;
        end
        dy  = longint'(tbl_y[hi]) - longint'(tbl_y[lo]);
        den = longint'(tbl_x[hi]) - longint'(tbl_x[lo]) + 1;
        if (den <= 0) den = 1;
        if (central) den = den * 2;
        q = (dy * ONE_L) / den;
        if (q > TAN_L) q = TAN_L;
        if (q < -TAN_L) q = -TAN_L;
        return q;
    endfunction

    function automatic curve_res_t eval_curve(logic [VAL_W-1:0] qx);
        curve_res_t r;
        int n, seg;
        longint x, x0, x1, y0, y1, dx, t, t2, t3, m0, m1, h00, h10, h01, h11, sum;
        n = (pt_count > NPTS) ? NPTS : int'(pt_count);
        x = longint'(qx);
        r.seg = '0;
        if (n == 0) begin r.value = qx; return r; end
        if (n == 1) begin r.value = tbl_y[0]; return r; end
        if (x <= longint'(tbl_x[0])) begin r.value = tbl_y[0]; return r; end
        if (x >= longint'(tbl_x[n-1])) begin r.value = tbl_y[n-1]; return r; end
        seg = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (x < longint'(tbl_x[i+1])) begin seg = i; break; end
        end
        r.seg = IDX_W'(seg);
        x0 = longint'(tbl_x[seg]); y0 = longint'(tbl_y[seg]);
        x1 = longint'(tbl_x[seg+1]); y1 = longint'(tbl_y[seg+1]);
        dx = x1 - x0;
        if (dx <= 0) begin r.value = tbl_y[seg]; return r; end
        t  = ((x - x0) * ONE_L) / dx;
        m0 = (tangent(seg, n) * dx) / ONE_L;
        m1 = (tangent(seg + 1, n) * dx) / ONE_L;
        t2 = (t * t) >> FRAC_BITS;
        t3 = (t2 * t) >> FRAC_BITS;
        h00 = 2 * t3 - 3 * t2 + ONE_L;
        h10 = t3 - 2 * t2 + t;
        h01 = -2 * t3 + 3 * t2;
        h11 = t3 - t2;
        sum = h00 * y0 + h10 * m0 + h01 * y1 + h11 * m1;
        if (sum <= 0) begin r.value = '0; return r; end
        sum = (sum + (ONE_L >> 1)) >> FRAC_BITS;
        if (sum > ONE_L) sum = ONE_L;
        r.value = VAL_W'(sum);
        return r;
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < 25);
    endfunction

    // drive one input transaction and update the predictor when it is taken
    task automatic send_item(input stim_row_t row);
        forever begin
            @(negedge aclk);
            if (roll_idle()) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= row.op;
                s_tdata  <= {1'b0, row.qx, row.py, row.px, row.idx};
                break;
            end
        end
        do @(posedge aclk); while (!s_tready);
        if (row.op == chce_pkg::OP_WRITE) begin
            tbl_x[row.idx] = row.px;
            tbl_y[row.idx] = row.py;
        end else if (row.typed) begin
            curve_q.push_back(row.res);
        end else begin
            curve_q.push_back(eval_curve(row.qx));
        end
    endtask

    task automatic set_count(input logic [4:0] cnt);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (curve_q.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pt_count = cnt;
    endtask

    function automatic stim_row_t wr_row(int idx, int px, int py);
        stim_row_t r;
        r = '{default: '0};
        r.op = chce_pkg::OP_WRITE; r.idx = IDX_W'(idx); r.px = VAL_W'(px); r.py = VAL_W'(py);
        return r;
    endfunction

    function automatic stim_row_t ev_row(int qx, bit typed = 0, int v = 0, int sg = 0);
        stim_row_t r;
        r = '{default: '0};
        r.op = chce_pkg::OP_EVAL; r.qx = VAL_W'(qx); r.typed = typed;
        r.res.value = VAL_W'(v); r.res.seg = IDX_W'(sg);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(int cnt);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.px = VAL_W'(cnt);
        return r;
    endfunction

    function automatic int rand_val();
        case ($urandom_range(9))
            0: return 0;
            1: return 65536;
            default: return $urandom_range(65536);
        endcase
    endfunction

    // result side: stall at random, check each transaction
    always @(negedge aclk) begin
        m_tready <= !roll_idle();
    end

    always @(posedge aclk) begin
        curve_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[16:0];
            got.seg   = m_tdata[20:17];
            if (curve_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result value=%0d seg=%0d",
                                           got.value, got.seg);
            end else begin
                want = curve_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: value exp %0d got %0d, seg exp %0d got %0d",
                                 want.value, got.value, want.seg, got.seg);
                end
            end
        end
    end

    // watchdog: count cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int xs[$];
        int n, n_items;
        logic [4:0] cnt;
        stim_row_t row;

        // empty table, single point, end cases
        dir_rows.push_back(ev_row(0, 1, 0, 0));
        dir_rows.push_back(ev_row(65536, 1, 65536, 0));
        dir_rows.push_back(ev_row(43690, 1, 43690, 0));
        dir_rows.push_back(wr_row(0, 30000, 65536));
        dir_rows.push_back(cfg_row(1));
        dir_rows.push_back(ev_row(0, 1, 65536, 0));
        dir_rows.push_back(ev_row(65536, 1, 65536, 0));
        // ascending four-point curve
        dir_rows.push_back(wr_row(0, 0, 0));
        dir_rows.push_back(wr_row(1, 20000, 60000));
        dir_rows.push_back(wr_row(2, 40000, 10000));
        dir_rows.push_back(wr_row(3, 65536, 65536));
        dir_rows.push_back(wr_row(15, 65536, 0));
        dir_rows.push_back(cfg_row(4));
        dir_rows.push_back(ev_row(0, 1, 0, 0));
        dir_rows.push_back(ev_row(65536, 1, 65536, 0));
        dir_rows.push_back(ev_row(10000));
        dir_rows.push_back(ev_row(20000));
        dir_rows.push_back(ev_row(52000));
        // out-of-order points: non-positive denominator and saturated tangent
        dir_rows.push_back(wr_row(0, 20000, 0));
        dir_rows.push_back(wr_row(1, 40000, 65536));
        dir_rows.push_back(wr_row(2, 5000, 65536));
        dir_rows.push_back(cfg_row(4));
        dir_rows.push_back(ev_row(30000));
        dir_rows.push_back(ev_row(39999));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) set_count(dir_rows[i].px[4:0]);
            else send_item(dir_rows[i]);
        end

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 4);
            case (ph)
                0: cnt = 2;
                1: cnt = 16;
                2: cnt = 17;
                3: cnt = 31;
                4: cnt = 3;
                5: cnt = 0;
                6: cnt = 1;
                default: cnt = 5'($urandom_range(31));
            endcase
            n = (cnt > NPTS) ? NPTS : int'(cnt);
            // load slots before the count covers them; mostly ascending x
            xs.delete();
            for (int i = 0; i < NPTS; i++) xs.push_back(rand_val());
            if ($urandom_range(4) != 0) xs.sort();
            for (int i = 0; i < NPTS; i++) send_item(wr_row(i, xs[i], rand_val()));
            set_count(cnt);
            n_items = 70;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(9) == 0) begin
                    row = wr_row($urandom_range(15), rand_val(), rand_val());
                end else if ($urandom_range(2) == 0 && n > 0) begin
                    // aim near a control point
                    row = ev_row(int'(tbl_x[$urandom_range(n - 1)]));
                    if (row.qx < 65536 && $urandom_range(1)) row.qx = row.qx + 1'b1;
                end else begin
                    row = ev_row(rand_val());
                end
                send_item(row);
            end
        end
        calm = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (curve_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
